[sv/false_position_root_finder_defines.svh]
// ---------------------------------------------------------------------------
// false_position_root_finder_defines.svh
// Assertion macros shared by the root finder modules.
// ---------------------------------------------------------------------------
`ifndef FALSE_POSITION_ROOT_FINDER_DEFINES_SVH
`define FALSE_POSITION_ROOT_FINDER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FPRF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPRF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/fprf_pkg.sv]
// ---------------------------------------------------------------------------
// fprf_pkg
// Types and constants of the false-position root finder.
// ---------------------------------------------------------------------------
`default_nettype none
package fprf_pkg;

	localparam int XW   = 32;
	localparam int VW   = 48;
	localparam int TOLW = 25;
	localparam int MAXW = 10;
	localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

	localparam logic [1:0] ST_CONV  = 2'd0;
	localparam logic [1:0] ST_LIMIT = 2'd1;
	localparam logic [1:0] ST_EQUAL = 2'd2;

	localparam logic CFG_TOL = 1'b0;
	localparam logic CFG_MAX = 1'b1;

	typedef struct packed {
		logic signed [XW-1:0] left_end;
		logic signed [XW-1:0] right_end;
	} in_item_t;

	typedef struct packed {
		logic signed [XW-1:0] root;
		logic signed [VW-1:0] value_at_root;
		logic [1:0]           status;
		logic [MAXW-1:0]      iterations_used;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EVAL_A, S_EVAL_B, S_CHECK, S_SEC, S_EVAL_C, S_DECIDE, S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture endpoints
		logic ev_start;  // start cubic evaluation
		logic [1:0] ev_sel; // 0 a, 1 b, 2 c
		logic sec_start; // start secant quotient
		logic finish_eq; // set result from endpoint a, status equal
		logic finish_lim;// status limit, keep current c
		logic finish_cv; // status converged
		logic update;    // replace an endpoint with c
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ev_done;
		logic sec_done;
		logic fa_eq_fb;
		logic conv;
	} sts_t;

	localparam logic [1:0] SEL_A = 2'd0;
	localparam logic [1:0] SEL_B = 2'd1;
	localparam logic [1:0] SEL_C = 2'd2;

endpackage
`default_nettype wire

[sv/fprf_cubic.sv]
// ---------------------------------------------------------------------------
// fprf_cubic
// Multi-cycle evaluation of x^3 + 4x^2 - 10 with rounding and saturation.
// Products are built from 32x32 partial products over several cycles.
// ---------------------------------------------------------------------------
`default_nettype none
module fprf_cubic #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [fprf_pkg::XW-1:0] x,
	output logic done,
	output logic signed [fprf_pkg::VW-1:0] fx
);
	localparam int VW = fprf_pkg::VW;

	// step counter: 0 idle, then partial products
	logic [3:0]  step_q;
	logic        neg_q;
	logic [31:0] m_q;       // |x|
	logic [63:0] a_q;       // operand (magnitude, 48 used)
	logic [95:0] acc_q;     // exact product
	logic [47:0] x2_q;
	logic [31:0] pp_s1;     // unused guard avoided: partial operand
	logic [63:0] prod_q;

	logic [127:0] rnd;
	logic [47:0]  mq;
	logic         sat;

	// round to nearest on magnitude, saturate at VAL_MAX
	assign rnd = {32'd0, acc_q} + (128'd1 << (FRAC_BITS - 1));
	assign sat = |(rnd >> (FRAC_BITS + VW - 1));
	assign mq  = sat ? fprf_pkg::VAL_MAX : rnd[FRAC_BITS +: VW];

	assign pp_s1 = (step_q == 4'd4) ? a_q[63:32] : a_q[31:0];

	// x2 never exceeds VAL_MAX, so its top bit is clear and 4*x2 stays positive
	logic signed [VW+1:0] sum;
	logic signed [VW+1:0] s3;
	assign s3  = neg_q ? -$signed({2'b00, mq}) : $signed({2'b00, mq});
	assign sum = s3 + $signed({x2_q, 2'b00}) - $signed((VW+2)'(10) <<< FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 4'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (step_q)
				4'd0: if (start) step_q <= 4'd1;
				4'd6: begin
					step_q <= 4'd0;
					done   <= 1'b1;
				end
				default: step_q <= step_q + 4'd1;
			endcase
		end
	end

	// datapath sequence: magnitude, x*x, round, x2*x low, x2*x high, round/sum
	always_ff @(posedge clk) begin
		unique case (step_q)
			4'd0: if (start) begin
				neg_q <= x[31];
				m_q   <= x[31] ? 32'(-x) : 32'(x);
			end
			4'd1: acc_q <= {32'd0, 64'(m_q) * 64'(m_q)};
			4'd2: begin
				x2_q <= mq;
				a_q  <= {16'd0, mq};
			end
			4'd3: prod_q <= 64'(pp_s1) * 64'(m_q);
			4'd4: begin
				acc_q  <= {32'd0, prod_q} + ({32'd0, 64'(pp_s1) * 64'(m_q)} << 32);
			end
			4'd5: begin
				if (sum > $signed({2'b00, fprf_pkg::VAL_MAX}))
					fx <= $signed(fprf_pkg::VAL_MAX);
				else if (sum < -$signed({2'b00, fprf_pkg::VAL_MAX}))
					fx <= -$signed(fprf_pkg::VAL_MAX);
				else
					fx <= sum[VW-1:0];
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[sv/fprf_divider.sv]
// ---------------------------------------------------------------------------
// fprf_divider
// Secant offset q = |fa*dx| / |dy|, restoring division one bit per cycle,
// quotient capped at 2^40, then c = a -/+ q saturated to 32 bits.
// ---------------------------------------------------------------------------
`default_nettype none
module fprf_divider (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [31:0] xa,
	input  wire logic signed [31:0] xb,
	input  wire logic signed [47:0] ya,
	input  wire logic signed [47:0] yb,
	output logic done,
	output logic signed [31:0] c
);
	localparam int CAP = 40;

	logic [1:0]  ph_q;     // 0 idle, 1 multiply, 2 divide, 3 finish
	logic [6:0]  bit_q;
	logic        neg_q;
	logic [47:0] fam_q;
	logic [32:0] dxm_q;
	logic [48:0] d_q;
	logic [81:0] num_q;
	logic [49:0] r_q;
	logic        big_q;
	logic [40:0] q_q;
	logic [1:0]  mstep_q;

	logic signed [32:0] dx;
	logic signed [48:0] dy;
	assign dx = 33'(xb) - 33'(xa);
	assign dy = 49'(yb) - 49'(ya);

	logic [49:0] rs;
	logic        ge;
	assign rs = {r_q[48:0], num_q[bit_q]};
	assign ge = rs >= {1'b0, d_q};

	logic signed [42:0] cs;
	assign cs = neg_q ? 43'(xa) + $signed({2'b00, q_q}) : 43'(xa) - $signed({2'b00, q_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (ph_q)
				2'd0: if (start) ph_q <= 2'd1;
				2'd1: if (mstep_q == 2'd1) ph_q <= 2'd2;
				2'd2: if (bit_q == 7'd0) ph_q <= 2'd3;
				2'd3: begin
					ph_q <= 2'd0;
					done <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ph_q)
			2'd0: if (start) begin
				neg_q   <= (ya[47] != dx[32]) != dy[48];
				fam_q   <= ya[47] ? 48'(-ya) : 48'(ya);
				dxm_q   <= dx[32] ? 33'(-dx) : 33'(dx);
				d_q     <= dy[48] ? 49'(-dy) : 49'(dy);
				mstep_q <= 2'd0;
				num_q   <= '0;
			end
			2'd1: begin
				// 48x33 product in two 24-bit halves
				if (mstep_q == 2'd0)
					num_q <= 82'(fam_q[23:0]) * 82'(dxm_q);
				else
					num_q <= num_q + ((82'(fam_q[47:24]) * 82'(dxm_q)) << 24);
				mstep_q <= mstep_q + 2'd1;
				bit_q   <= 7'd81;
				r_q     <= '0;
				big_q   <= 1'b0;
				q_q     <= '0;
			end
			2'd2: begin
				if (ge) begin
					r_q <= rs - {1'b0, d_q};
					if (bit_q >= 7'(CAP)) big_q <= 1'b1;
					else q_q[bit_q[5:0]] <= 1'b1;
				end else begin
					r_q <= rs;
				end
				bit_q <= bit_q - 7'd1;
			end
			2'd3: begin
				if (big_q) q_q <= 41'd1 << CAP;
			end
		endcase
	end

	// saturate c; big case uses cap value directly
	logic signed [42:0] cf;
	assign cf = big_q ? (neg_q ? 43'(xa) + (43'sd1 <<< CAP) : 43'(xa) - (43'sd1 <<< CAP)) : cs;
	always_comb begin
		if (cf > 43'sh7FFFFFFF) c = 32'sh7FFFFFFF;
		else if (cf < -43'sh80000000) c = 32'sh80000000;
		else c = cf[31:0];
	end
endmodule
`default_nettype wire

[sv/fprf_datapath.sv]
// ---------------------------------------------------------------------------
// fprf_datapath
// Endpoint registers, shared cubic and divider units, result register.
// ---------------------------------------------------------------------------
`default_nettype none
module fprf_datapath #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire fprf_pkg::cmd_t cmd,
	output fprf_pkg::sts_t sts,
	input  wire fprf_pkg::in_item_t in_item,
	input  wire logic [fprf_pkg::TOLW-1:0] tol,
	output fprf_pkg::out_item_t res
);
	logic signed [31:0] a_q, b_q, c_q;
	logic signed [47:0] fa_q, fb_q, fc_q;
	logic ev_done, sec_done;
	logic signed [31:0] ev_x, sec_c;
	logic signed [47:0] fx;

	always_comb begin
		unique case (cmd.ev_sel)
			fprf_pkg::SEL_A: ev_x = a_q;
			fprf_pkg::SEL_B: ev_x = b_q;
			default:         ev_x = c_q;
		endcase
	end

	fprf_cubic #(.FRAC_BITS(FRAC_BITS)) u_cubic (
		.clk(clk), .arst_n(arst_n), .start(cmd.ev_start), .x(ev_x),
		.done(ev_done), .fx(fx)
	);

	fprf_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.sec_start),
		.xa(a_q), .xb(b_q), .ya(fa_q), .yb(fb_q), .done(sec_done), .c(sec_c)
	);

	logic [47:0] fcm;
	assign fcm = fc_q[47] ? 48'(-fc_q) : 48'(fc_q);

	assign sts.ev_done  = ev_done;
	assign sts.sec_done = sec_done;
	assign sts.fa_eq_fb = (fa_q == fb_q);
	assign sts.conv     = (fc_q == '0) || (fcm < 48'(tol));

	// endpoint and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= in_item.left_end;
			b_q <= in_item.right_end;
			res.iterations_used <= '0;
		end
		if (ev_done) begin
			unique case (cmd.ev_sel)
				fprf_pkg::SEL_A: begin
					fa_q <= fx;
					c_q  <= a_q;
					fc_q <= fx;
				end
				fprf_pkg::SEL_B: fb_q <= fx;
				default: begin
					fc_q <= fx;
					res.iterations_used <= res.iterations_used + 10'd1;
				end
			endcase
		end
		if (sec_done) c_q <= sec_c;
		if (cmd.update) begin
			if ((fa_q[47] && !fc_q[47] && fc_q != '0) || (!fa_q[47] && fa_q != '0 && fc_q[47])) begin
				b_q  <= c_q;
				fb_q <= fc_q;
			end else begin
				a_q  <= c_q;
				fa_q <= fc_q;
			end
		end
		if (cmd.finish_eq) begin
			res.root          <= a_q;
			res.value_at_root <= fa_q;
			res.status        <= fprf_pkg::ST_EQUAL;
		end
		if (cmd.finish_lim) begin
			res.root          <= c_q;
			res.value_at_root <= fc_q;
			res.status        <= fprf_pkg::ST_LIMIT;
		end
		if (cmd.finish_cv) begin
			res.root          <= c_q;
			res.value_at_root <= fc_q;
			res.status        <= fprf_pkg::ST_CONV;
		end
	end
endmodule
`default_nettype wire

[sv/fprf_ctrl.sv]
// ---------------------------------------------------------------------------
// fprf_ctrl
// Iteration sequencer: evaluate ends, secant step, evaluate, decide.
// ---------------------------------------------------------------------------
`default_nettype none
`include "false_position_root_finder_defines.svh"
module fprf_ctrl #(
	parameter int ITER_BITS = 10
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire logic [ITER_BITS-1:0] max_it,
	input  wire fprf_pkg::sts_t sts,
	output fprf_pkg::cmd_t cmd
);
	fprf_pkg::state_t state_q, state_d;
	logic [ITER_BITS-1:0] cnt_q;
	logic busy_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fprf_pkg::S_IDLE:   if (in_valid) state_d = fprf_pkg::S_EVAL_A;
			fprf_pkg::S_EVAL_A: if (sts.ev_done) state_d = fprf_pkg::S_EVAL_B;
			fprf_pkg::S_EVAL_B: if (sts.ev_done) state_d = fprf_pkg::S_CHECK;
			fprf_pkg::S_CHECK:
				if (cnt_q == max_it || sts.fa_eq_fb) state_d = fprf_pkg::S_OUT;
				else state_d = fprf_pkg::S_SEC;
			fprf_pkg::S_SEC:    if (sts.sec_done) state_d = fprf_pkg::S_EVAL_C;
			fprf_pkg::S_EVAL_C: if (sts.ev_done) state_d = fprf_pkg::S_DECIDE;
			fprf_pkg::S_DECIDE:
				state_d = sts.conv ? fprf_pkg::S_OUT : fprf_pkg::S_CHECK;
			fprf_pkg::S_OUT:    if (out_ready) state_d = fprf_pkg::S_IDLE;
			default:            state_d = fprf_pkg::S_IDLE;
		endcase
	end

	// commands; busy_q marks a started unit so start is one pulse
	always_comb begin
		cmd = '0;
		in_ready  = (state_q == fprf_pkg::S_IDLE);
		out_valid = (state_q == fprf_pkg::S_OUT);
		cmd.load  = in_ready && in_valid;
		unique case (state_q)
			fprf_pkg::S_EVAL_A: begin
				cmd.ev_sel = fprf_pkg::SEL_A;
				cmd.ev_start = !busy_q;
			end
			fprf_pkg::S_EVAL_B: begin
				cmd.ev_sel = fprf_pkg::SEL_B;
				cmd.ev_start = !busy_q;
			end
			fprf_pkg::S_EVAL_C: begin
				cmd.ev_sel = fprf_pkg::SEL_C;
				cmd.ev_start = !busy_q;
			end
			fprf_pkg::S_SEC: cmd.sec_start = !busy_q;
			fprf_pkg::S_CHECK: begin
				cmd.finish_eq  = sts.fa_eq_fb && cnt_q != max_it;
				cmd.finish_lim = cnt_q == max_it;
			end
			fprf_pkg::S_DECIDE: begin
				cmd.finish_cv = sts.conv;
				cmd.update    = !sts.conv;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fprf_pkg::S_IDLE;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) busy_q <= 1'b0;
			else if (cmd.ev_start || cmd.sec_start) busy_q <= 1'b1;
			if (cmd.load) cnt_q <= '0;
			else if (state_q == fprf_pkg::S_EVAL_C && sts.ev_done)
				cnt_q <= cnt_q + ITER_BITS'(1);
		end
	end

	`FPRF_ASSERT_IMP(a_no_accept_busy, in_ready, state_q == fprf_pkg::S_IDLE, "accept while busy")
	`FPRF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
	`FPRF_ASSERT_IMP(a_one_finish, 1'b1, $onehot0({cmd.finish_eq, cmd.finish_lim, cmd.finish_cv}), "multi finish")
	`FPRF_ASSERT_IMP(a_cnt_lim, state_q == fprf_pkg::S_SEC, cnt_q != max_it, "over limit")
endmodule
`default_nettype wire

[sv/false_position_root_finder.sv]
// Secant steps use the bit-per-cycle divider (82 steps).
// Throughput: one item at a time; next accept after the result transfer.
// Reset: arst_n clears the sequencer and reloads tolerance 168, limit 200.
// Input ready only while idle; result held until taken.
// ---------------------------------------------------------------------------
// false_position_root_finder
// False-position root search on x^3+4x^2-10 with a controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none
module false_position_root_finder #(
	parameter int FRAC_BITS = 24,
	parameter int ITER_BITS = 10
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire fprf_pkg::in_item_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output fprf_pkg::out_item_t out_data,
	input  wire logic cfg_we,
	input  wire logic cfg_index,
	input  wire logic [fprf_pkg::TOLW-1:0] cfg_wdata
);
	logic [fprf_pkg::TOLW-1:0] tol_q;
	logic [ITER_BITS-1:0] max_q;
	fprf_pkg::cmd_t cmd;
	fprf_pkg::sts_t sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= fprf_pkg::TOLW'(168);
			max_q <= ITER_BITS'(200);
		end else if (cfg_we) begin
			if (cfg_index == fprf_pkg::CFG_TOL) tol_q <= cfg_wdata;
			else max_q <= ITER_BITS'(cfg_wdata[fprf_pkg::MAXW-1:0]);
		end
	end

	fprf_ctrl #(.ITER_BITS(ITER_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .max_it(max_q),
		.sts(sts), .cmd(cmd)
	);

	fprf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_item(in_data),
		.tol(tol_q), .res(out_data)
	);
endmodule
`default_nettype wire
